@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every cycle outside reset.
`define CHK_IMPL(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("lbl");

// Next-cycle implication checked outside reset.
`define CHK_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("lbl");

`endif

@@ hw/rtl/maes_pkg.sv @@
package maes_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_DONE
  } state_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [10] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  localparam logic [0:0] REG_KEY_HIGH = 1'b0;
  localparam logic [0:0] REG_KEY_LOW  = 1'b1;

  typedef logic [7:0] blk_t [16];

  // Mask bundle held for one block.
  typedef struct packed {
    logic [7:0]  m;
    logic [7:0]  mp;
    logic [31:0] rm;
    logic [31:0] mc;
  } masks_t;

  function automatic logic [7:0] gf_dbl(input logic [7:0] v);
    gf_dbl = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] msbox(input logic [7:0] v, input logic [7:0] m,
                                       input logic [7:0] mp);
    msbox = SBOX[v ^ m] ^ mp;
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] a);
    logic [7:0] a0, a1, a2, a3;
    a0 = a[31:24]; a1 = a[23:16]; a2 = a[15:8]; a3 = a[7:0];
    mix_col = {gf_dbl(a0 ^ a1) ^ a1 ^ a2 ^ a3,
               a0 ^ gf_dbl(a1 ^ a2) ^ a2 ^ a3,
               a0 ^ a1 ^ gf_dbl(a2 ^ a3) ^ a3,
               gf_dbl(a0 ^ a3) ^ a0 ^ a1 ^ a2};
  endfunction

endpackage

@@ hw/rtl/maes_if.sv @@
interface maes_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] plaintext_high;
  logic [63:0] plaintext_low;
  logic [7:0]  sbox_in_mask;
  logic [7:0]  sbox_out_mask;
  logic [7:0]  row0_mask;
  logic [7:0]  row1_mask;
  logic [7:0]  row2_mask;
  logic [7:0]  row3_mask;
  modport source (output valid, plaintext_high, plaintext_low, sbox_in_mask, sbox_out_mask,
                  row0_mask, row1_mask, row2_mask, row3_mask, input ready);
  modport sink (input valid, plaintext_high, plaintext_low, sbox_in_mask, sbox_out_mask,
                row0_mask, row1_mask, row2_mask, row3_mask, output ready);
endinterface

interface maes_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] ciphertext_high;
  logic [63:0] ciphertext_low;
  modport source (output valid, ciphertext_high, ciphertext_low, input ready);
  modport sink (input valid, ciphertext_high, ciphertext_low, output ready);
endinterface

interface maes_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/maes_round.sv @@
// One masked AES round: state and round key both advance.
module maes_round (
  input  logic [127:0]         st,
  input  logic [127:0]         rk,
  input  maes_pkg::masks_t     mk,
  input  logic [7:0]           rcon,
  input  logic                 last,
  output logic [127:0]         st_next,
  output logic [127:0]         rk_next
);
  logic [7:0] s [16];
  logic [7:0] k [16];
  logic [7:0] nk [16];
  logic [7:0] sb [16];
  logic [7:0] sr [16];
  logic [7:0] mx [16];
  logic [7:0] mc [4];
  logic [7:0] rm [4];
  logic [31:0] col;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mc[i] = mk.mc[31-8*i -: 8];
      rm[i] = mk.rm[31-8*i -: 8];
    end
    for (int i = 0; i < 16; i++) begin
      s[i] = st[127-8*i -: 8];
      k[i] = rk[127-8*i -: 8];
    end
    for (int j = 0; j < 4; j++) begin
      nk[j] = maes_pkg::msbox(k[12 + ((j + 1) % 4)] ^ mc[(j + 1) % 4], mk.m, mk.mp)
              ^ k[j] ^ mk.mp ^ ((j == 0) ? rcon : 8'h00);
    end
    for (int i = 4; i < 16; i++) begin
      nk[i] = nk[i-4] ^ k[i] ^ mc[i%4] ^ mk.m;
    end
    if (last) begin
      for (int i = 0; i < 16; i++) nk[i] = nk[i] ^ mc[i%4] ^ mk.m ^ mk.mp;
    end
    for (int i = 0; i < 16; i++) sb[i] = maes_pkg::msbox(s[i], mk.m, mk.mp);
    for (int i = 0; i < 16; i++) sr[i] = sb[(i + 4 * (i % 4)) % 16];
    for (int c = 0; c < 4; c++) begin
      col = {sr[4*c] ^ rm[0] ^ mk.mp, sr[4*c+1] ^ rm[1] ^ mk.mp,
             sr[4*c+2] ^ rm[2] ^ mk.mp, sr[4*c+3] ^ rm[3] ^ mk.mp};
      col = maes_pkg::mix_col(col);
      for (int r = 0; r < 4; r++) mx[4*c+r] = last ? sr[4*c+r] : col[31-8*r -: 8];
    end
    for (int i = 0; i < 16; i++) begin
      st_next[127-8*i -: 8] = mx[i] ^ nk[i];
      rk_next[127-8*i -: 8] = nk[i];
    end
  end
endmodule

@@ hw/rtl/masked_aes128_encrypt_top.sv @@
// Masked AES-128 encryption, one shared round unit.
// Each block is loaded and whitened at the accept edge, then runs 10 rounds before its result is valid.
// Each block passes through the round state, then the result state until taken, then back to idle.
// Not ready for input while a block is in flight or its result waits.
// Synchronous active-high rst clears control state and both key registers.
module masked_aes128_encrypt_top (
  input  logic              clk,
  input  logic              rst,
  maes_in_if.sink           in_ch,
  maes_out_if.source        out_ch,
  maes_cfg_if.sink          cfg
);
  maes_pkg::state_t state, state_next;
  logic [63:0]      key_high, key_low;
  logic [127:0]     st, rk, st_rnd, rk_rnd, st_init, rk_init;
  logic [127:0]     key_all, pt_all;
  maes_pkg::masks_t mk, mk_in;
  logic [3:0]       rnd;
  logic [31:0]      mc_in;
  logic [7:0]       mcb [4];

  // Configuration is always taken.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        maes_pkg::REG_KEY_HIGH: key_high <= cfg.data;
        maes_pkg::REG_KEY_LOW:  key_low  <= cfg.data;
        default: ;
      endcase
    end
  end

  // Output masks from row masks via one MixColumns column.
  always_comb begin
    mc_in = maes_pkg::mix_col({in_ch.row0_mask, in_ch.row1_mask,
                               in_ch.row2_mask, in_ch.row3_mask});
    for (int i = 0; i < 4; i++) mcb[i] = mc_in[31-8*i -: 8];
    mk_in.m  = in_ch.sbox_in_mask;
    mk_in.mp = in_ch.sbox_out_mask;
    mk_in.rm = {in_ch.row0_mask, in_ch.row1_mask, in_ch.row2_mask, in_ch.row3_mask};
    mk_in.mc = mc_in;
    key_all  = {key_high, key_low};
    pt_all   = {in_ch.plaintext_high, in_ch.plaintext_low};
    // Round key 0 masked with mX' ^ m; state whitened keeps mask m.
    for (int i = 0; i < 16; i++) begin
      rk_init[127-8*i -: 8] = key_all[127-8*i -: 8] ^ mcb[i%4] ^ in_ch.sbox_in_mask;
      st_init[127-8*i -: 8] = pt_all[127-8*i -: 8] ^ mcb[i%4] ^ rk_init[127-8*i -: 8];
    end
  end

  maes_round u_round (
    .st      (st),
    .rk      (rk),
    .mk      (mk),
    .rcon    (maes_pkg::RCON[rnd]),
    .last    (rnd == 4'd9),
    .st_next (st_rnd),
    .rk_next (rk_rnd)
  );

  assign in_ch.ready         = (state == maes_pkg::ST_IDLE);
  assign out_ch.valid        = (state == maes_pkg::ST_DONE);
  assign out_ch.ciphertext_high = st[127:64];
  assign out_ch.ciphertext_low  = st[63:0];

  always_comb begin
    state_next = state;
    case (state)
      maes_pkg::ST_IDLE:  if (in_ch.valid) state_next = maes_pkg::ST_ROUND;
      maes_pkg::ST_ROUND: if (rnd == 4'd9) state_next = maes_pkg::ST_DONE;
      maes_pkg::ST_DONE:  if (out_ch.ready) state_next = maes_pkg::ST_IDLE;
      default:            state_next = maes_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= maes_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // Round counter and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rnd <= '0;
    end else if (state == maes_pkg::ST_IDLE) begin
      rnd <= '0;
    end else if (state == maes_pkg::ST_ROUND) begin
      rnd <= rnd + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == maes_pkg::ST_IDLE && in_ch.valid) begin
      st <= st_init;
      rk <= rk_init;
      mk <= mk_in;
    end else if (state == maes_pkg::ST_ROUND) begin
      st <= st_rnd;
      rk <= rk_rnd;
    end
  end
endmodule

@@ hw/rtl/maes_checker.sv @@
`include "assert_macros.svh"
module maes_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [127:0] out_data
);
  `CHK_IMPL(a_no_overlap, clk, rst, out_valid, !in_ready)
  `CHK_NEXT(a_hold_result, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))
  `CHK_NEXT(a_busy_after_take, clk, rst, in_valid && in_ready, !in_ready && !out_valid)
  `CHK_NEXT(a_idle_after_out, clk, rst, out_valid && out_ready, in_ready)
endmodule

bind masked_aes128_encrypt_top maes_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  ({out_ch.ciphertext_high, out_ch.ciphertext_low})
);
